// ===== hw/rtl/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

  localparam int unsigned PayloadDepthDef = 256;
  localparam logic [7:0]  CrcPoly         = 8'h91;

  localparam logic [15:0] TimeoutRst      = 16'd2500;
  localparam logic [7:0]  ErrorLimitRst   = 8'd5;
  localparam logic [7:0]  StartByteRst    = 8'd50;
  localparam logic [7:0]  EndByteRst      = 8'd13;
  localparam logic [7:0]  RetransTypeRst  = 8'd8;

  typedef enum logic [2:0] {
    CFG_TIMEOUT   = 3'd0,
    CFG_ERR_LIMIT = 3'd1,
    CFG_START     = 3'd2,
    CFG_END       = 3'd3,
    CFG_RETRANS   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    VD_GOOD    = 3'd0,
    VD_CRC_ERR = 3'd1,
    VD_BAD_END = 3'd2,
    VD_TIMEOUT = 3'd3,
    VD_RETRANS = 3'd4,
    VD_READ    = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_RESET  = 2'd2,
    ACT_RESEND = 2'd3
  } action_t;

  typedef enum logic {
    PH_HUNT = 1'b0,
    PH_RECV = 1'b1
  } phase_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  error_limit;
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  retransmit_type;
  } cfg_t;

  typedef struct packed {
    verdict_t   verdict;
    action_t    action;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [7:0] error_total;
    logic       is_read;
  } result_t;

  // reflected crc-8, poly xored in before each shift
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = c ^ CrcPoly;
      end
      c = c >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfr_payload_mem.sv =====
`default_nettype none

module sfr_payload_mem #(
  parameter int unsigned DEPTH = sfr_pkg::PayloadDepthDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_frame_ctrl.sv =====
`default_nettype none

module sfr_frame_ctrl #(
  parameter int unsigned DEPTH = sfr_pkg::PayloadDepthDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sfr_pkg::cfg_t   cfg,
  input  wire logic            req_acc,
  input  wire logic [1:0]      req_op,
  input  wire logic [7:0]      req_byte,
  output logic                 res_valid,
  output sfr_pkg::result_t     res,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data
);

  sfr_pkg::phase_t phase_r, phase_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  crc_rx_r, crc_rx_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [7:0]  err_r, err_nxt;

  sfr_pkg::op_t    op;
  logic [8:0]      crc_pos;
  logic [8:0]      slot;
  logic            timed_out;
  logic            at_end;
  logic [7:0]      err_inc;
  sfr_pkg::action_t err_act;
  logic [7:0]      crc_new;

  assign op        = sfr_pkg::op_t'(req_op);
  assign crc_pos   = {1'b0, len_r} + 9'd2;
  assign slot      = pos_r - 9'd2;
  assign timed_out = (elapsed_r >= cfg.timeout_ms);
  assign at_end    = (pos_r > crc_pos);
  assign err_inc   = (err_r == 8'hFF) ? err_r : err_r + 8'd1;
  assign err_act   = (err_inc > cfg.error_limit) ? sfr_pkg::ACT_RESET : sfr_pkg::ACT_REPORT;
  assign crc_new   = sfr_pkg::crc_update(crc_r, req_byte);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (req_acc) begin
      unique case (phase_r)
        sfr_pkg::PH_HUNT: begin
          if (op == sfr_pkg::OP_BYTE && req_byte == cfg.start_byte) begin
            phase_nxt = sfr_pkg::PH_RECV;
          end
        end
        sfr_pkg::PH_RECV: begin
          if ((op == sfr_pkg::OP_TICK && timed_out) || (op == sfr_pkg::OP_BYTE && at_end)) begin
            phase_nxt = sfr_pkg::PH_HUNT;
          end
        end
        default: ;
      endcase
    end
  end

  // frame datapath and result
  always_comb begin
    pos_nxt     = pos_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    crc_nxt     = crc_r;
    crc_rx_nxt  = crc_rx_r;
    elapsed_nxt = elapsed_r;
    err_nxt     = err_r;
    res_valid   = 1'b0;
    res.verdict      = sfr_pkg::VD_GOOD;
    res.action       = sfr_pkg::ACT_NONE;
    res.frame_type   = type_r;
    res.frame_length = len_r;
    res.error_total  = err_r;
    res.is_read      = 1'b0;
    wr_en   = 1'b0;
    wr_addr = slot[AW-1:0];
    wr_data = req_byte;
    if (req_acc) begin
      unique case (op)
        sfr_pkg::OP_READ: begin
          res_valid        = 1'b1;
          res.verdict      = sfr_pkg::VD_READ;
          res.frame_type   = 8'd0;
          res.frame_length = 8'd0;
          res.is_read      = 1'b1;
        end
        sfr_pkg::OP_TICK: begin
          if (phase_r == sfr_pkg::PH_RECV) begin
            if (timed_out) begin
              err_nxt         = err_inc;
              res_valid       = 1'b1;
              res.verdict     = sfr_pkg::VD_TIMEOUT;
              res.action      = err_act;
              res.error_total = err_inc;
            end else begin
              elapsed_nxt = elapsed_r + 16'd1;
            end
          end
        end
        sfr_pkg::OP_BYTE: begin
          if (phase_r == sfr_pkg::PH_HUNT) begin
            if (req_byte == cfg.start_byte) begin
              pos_nxt     = 9'd0;
              type_nxt    = 8'd0;
              len_nxt     = 8'd0;
              crc_nxt     = 8'd0;
              crc_rx_nxt  = 8'd0;
              elapsed_nxt = 16'd0;
            end
          end else if (pos_r == 9'd0) begin
            type_nxt = req_byte;
            crc_nxt  = crc_new;
            pos_nxt  = 9'd1;
          end else if (pos_r == 9'd1) begin
            len_nxt = req_byte;
            crc_nxt = crc_new;
            pos_nxt = 9'd2;
          end else if (pos_r < crc_pos) begin
            // payload beyond the store still enters the crc
            wr_en   = (slot < 9'(DEPTH));
            crc_nxt = crc_new;
            pos_nxt = pos_r + 9'd1;
          end else if (pos_r == crc_pos) begin
            crc_rx_nxt = req_byte;
            pos_nxt    = pos_r + 9'd1;
          end else begin
            res_valid = 1'b1;
            if (req_byte != cfg.end_byte) begin
              err_nxt         = err_inc;
              res.verdict     = sfr_pkg::VD_BAD_END;
              res.action      = err_act;
              res.error_total = err_inc;
            end else if (crc_rx_r != crc_r) begin
              err_nxt         = err_inc;
              res.verdict     = sfr_pkg::VD_CRC_ERR;
              res.action      = err_act;
              res.error_total = err_inc;
            end else if (type_r == cfg.retransmit_type) begin
              res.verdict = sfr_pkg::VD_RETRANS;
              res.action  = sfr_pkg::ACT_RESEND;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sfr_pkg::PH_HUNT;
      pos_r     <= 9'd0;
      type_r    <= 8'd0;
      len_r     <= 8'd0;
      crc_r     <= 8'd0;
      crc_rx_r  <= 8'd0;
      elapsed_r <= 16'd0;
      err_r     <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      crc_r     <= crc_nxt;
      crc_rx_r  <= crc_rx_nxt;
      elapsed_r <= elapsed_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/serial_frame_receiver_crc.sv =====
// path: a result passes through stage 1 (frame logic and payload memory read),
// then the output register
// throughput: one request per cycle while the result channel does not stall; crc update
// and frame state logic are combinational, payload store has one write and one read port
// reset: rst_n synchronous active low; clears frame state, error count and config
// to defaults; the payload store is not cleared, so no clearing pass is needed
`default_nettype none

module serial_frame_receiver_crc #(
  parameter int unsigned PAYLOAD_DEPTH = sfr_pkg::PayloadDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [7:0]  in_read_index,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_verdict,
  output logic [1:0]       out_action,
  output logic [7:0]       out_frame_type,
  output logic [7:0]       out_frame_length,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_error_total,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);

  sfr_pkg::cfg_t cfg_r;

  logic             req_acc;
  logic             res_valid;
  sfr_pkg::result_t res;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic             rd_in_range;
  logic [7:0]       rd_data;

  // stage 1: result waiting for payload read data
  logic             s1_valid_r;
  sfr_pkg::result_t s1_res_r;
  logic             s1_in_range_r;
  logic             s1_adv;

  // output register
  logic             out_valid_r;
  sfr_pkg::result_t out_res_r;
  logic [7:0]       out_pbyte_r;

  // config registers, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms      <= sfr_pkg::TimeoutRst;
      cfg_r.error_limit     <= sfr_pkg::ErrorLimitRst;
      cfg_r.start_byte      <= sfr_pkg::StartByteRst;
      cfg_r.end_byte        <= sfr_pkg::EndByteRst;
      cfg_r.retransmit_type <= sfr_pkg::RetransTypeRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfr_pkg::CFG_TIMEOUT:   cfg_r.timeout_ms      <= cfg_wdata;
        sfr_pkg::CFG_ERR_LIMIT: cfg_r.error_limit     <= cfg_wdata[7:0];
        sfr_pkg::CFG_START:     cfg_r.start_byte      <= cfg_wdata[7:0];
        sfr_pkg::CFG_END:       cfg_r.end_byte        <= cfg_wdata[7:0];
        sfr_pkg::CFG_RETRANS:   cfg_r.retransmit_type <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // stage 1 moves on whenever the output register is free or being drained;
  // a new request is taken whenever stage 1 is empty or moving on
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign req_acc  = in_valid && in_ready;

  // reads past the store answer zero
  assign rd_in_range = ({1'b0, in_read_index} < 9'(PAYLOAD_DEPTH));
  assign rd_en       = req_acc && (in_op == sfr_pkg::OP_READ) && rd_in_range;

  sfr_frame_ctrl #(
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_acc   (req_acc),
    .req_op    (in_op),
    .req_byte  (in_rx_byte),
    .res_valid (res_valid),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // read data register only reloads on the next read request, which cannot be
  // accepted before stage 1 hands its result on
  sfr_payload_mem #(
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (in_read_index[AW-1:0]),
    .rd_data (rd_data)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= req_acc && res_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_res_r      <= res;
      s1_in_range_r <= rd_in_range;
    end
  end

  // output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r   <= s1_res_r;
      out_pbyte_r <= (s1_res_r.is_read && s1_in_range_r) ? rd_data : 8'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_res_r.verdict;
  assign out_action       = out_res_r.action;
  assign out_frame_type   = out_res_r.frame_type;
  assign out_frame_length = out_res_r.frame_length;
  assign out_payload_byte = out_pbyte_r;
  assign out_error_total  = out_res_r.error_total;

endmodule

`default_nettype wire
